// ----- src/tps_pkg.sv -----
package tps_pkg;

  localparam int unsigned MaxRes            = 4;
  localparam int unsigned CntW              = $clog2(MaxRes + 1);
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChS     = 8'h73;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChM     = 8'h6D;
  localparam logic [7:0] ChD     = 8'h64;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChE     = 8'h65;
  localparam logic [7:0] ChV     = 8'h76;
  localparam logic [7:0] ChL     = 8'h6C;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_LETTER,
    CLS_DIGIT,
    CLS_OTHER
  } cls_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       chunk_end;
    logic       text_end;
  } res_t;

  typedef struct packed {
    logic [CntW-1:0]         cnt;
    res_t [MaxRes-1:0]       res;
  } bundle_t;

endpackage

// ----- src/text_pretokenizer_splitter.sv -----
// Results of an accepted transaction pass the queue, the bundle register and the output register before the ports.
// Throughput: one input byte per cycle while the result side keeps up; each byte
// yields 0 to 4 results and the output stage drains one result per cycle, so the
// sustained input rate is set by the result count per byte.
// Reset: asynchronous, active low; clears the splitter state, empties the queue and clears the output stage.
module text_pretokenizer_splitter import tps_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char_i,
  input  logic       last_of_text_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       chunk_end_o,
  output logic       text_end_o
);

  logic    accept;
  bundle_t front_bundle, q_data;
  logic    q_full, q_valid, q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  tps_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .in_char_i,
    .last_of_text_i,
    .bundle_o       (front_bundle)
  );

  tps_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .wr_en_i    (accept && (front_bundle.cnt != '0)),
    .wr_data_i  (front_bundle),
    .full_o     (q_full),
    .rd_en_i    (q_pop),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_data)
  );

  tps_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .empty,
    .pop,
    .out_char_o,
    .chunk_end_o,
    .text_end_o
  );

endmodule

// ----- src/tps_front.sv -----
module tps_front import tps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_char_i,
  input  logic       last_of_text_i,
  output bundle_t    bundle_o
);

  typedef struct packed {
    logic [7:0] h0;
    logic [7:0] h1;
    logic [1:0] hc;
    cls_e       rc;
    logic [1:0] sr;
    logic       pd;
    bundle_t    b;
  } ctx_t;

  logic [7:0] h0_q, h0_d, h1_q, h1_d;
  logic [1:0] hc_q, hc_d, sr_q, sr_d;
  cls_e       rc_q, rc_d;
  logic       pd_q, pd_d;

  function automatic logic is_ws(logic [7:0] c);
    return c == ChSpace || c == ChLf || c == ChTab || c == ChCr || c == ChFf || c == ChVt;
  endfunction

  function automatic cls_e class_of(logic [7:0] c);
    if ((c >= ChLowA && c <= ChLowZ) || (c >= ChUpA && c <= ChUpZ)) return CLS_LETTER;
    if (c >= Ch0 && c <= Ch9) return CLS_DIGIT;
    return CLS_OTHER;
  endfunction

  function automatic ctx_t emit(ctx_t x, logic [7:0] ch, logic e);
    if (x.b.cnt < CntW'(MaxRes)) begin
      x.b.res[x.b.cnt[$clog2(MaxRes)-1:0]].ch        = ch;
      x.b.res[x.b.cnt[$clog2(MaxRes)-1:0]].chunk_end = e;
      x.b.res[x.b.cnt[$clog2(MaxRes)-1:0]].text_end  = 1'b0;
      x.b.cnt = x.b.cnt + CntW'(1);
    end
    return x;
  endfunction

  function automatic ctx_t start_space(ctx_t x, logic [7:0] c);
    x.h0 = c;
    x.hc = 2'd1;
    x.sr = 2'd1;
    x.rc = CLS_NONE;
    return x;
  endfunction

  function automatic ctx_t start_chunk(ctx_t x, logic [7:0] c);
    x.sr = 2'd0;
    x.h0 = c;
    x.hc = 2'd1;
    if (c == ChApos) begin
      x.rc = CLS_NONE;
    end else begin
      if (x.pd) x = emit(x, ChSpace, 1'b0);
      x.pd = 1'b0;
      x.rc = class_of(c);
    end
    return x;
  endfunction

  function automatic ctx_t word_byte(ctx_t x, logic [7:0] c);
    if (is_ws(c)) begin
      x = emit(x, x.h0, 1'b1);
      x = start_space(x, c);
    end else if (class_of(c) == x.rc) begin
      x = emit(x, x.h0, 1'b0);
      x.h0 = c;
    end else begin
      x = emit(x, x.h0, 1'b1);
      x = start_chunk(x, c);
    end
    return x;
  endfunction

  function automatic ctx_t apos_fallback(ctx_t x);
    if (x.pd) x = emit(x, ChSpace, 1'b0);
    x.pd = 1'b0;
    x.rc = CLS_OTHER;
    x.sr = 2'd0;
    x.h0 = ChApos;
    x.hc = 2'd1;
    return x;
  endfunction

  function automatic ctx_t feed(ctx_t x, logic [7:0] c);
    logic [7:0] second;
    second = x.h1;
    if (x.rc != CLS_NONE) begin
      x = word_byte(x, c);
    end else if (x.sr != 2'd0) begin
      if (is_ws(c)) begin
        x = emit(x, x.h0, 1'b0);
        x.h0 = c;
        x.sr = 2'd2;
      end else begin
        if (x.sr >= 2'd2) begin
          x = emit(x, x.h0, 1'b1);
          x.pd = 1'b0;
        end else begin
          x.pd = 1'b1;
        end
        x = start_chunk(x, c);
      end
    end else if (x.hc == 2'd0) begin
      if (is_ws(c)) x = start_space(x, c);
      else x = start_chunk(x, c);
    end else if (x.hc == 2'd1) begin
      if (c == ChS || c == ChT || c == ChM || c == ChD) begin
        x = emit(x, ChApos, 1'b0);
        x = emit(x, c, 1'b1);
        x.pd = 1'b0;
        x.hc = 2'd0;
      end else if (c == ChR || c == ChV || c == ChL) begin
        x.h1 = c;
        x.hc = 2'd2;
      end else begin
        x = apos_fallback(x);
        x = word_byte(x, c);
      end
    end else begin
      x.h1 = 8'd0;
      if ((second == ChR && c == ChE) || (second == ChV && c == ChE) ||
          (second == ChL && c == ChL)) begin
        x = emit(x, ChApos, 1'b0);
        x = emit(x, second, 1'b0);
        x = emit(x, c, 1'b1);
        x.pd = 1'b0;
        x.hc = 2'd0;
      end else begin
        x = apos_fallback(x);
        x = word_byte(x, second);
        x = word_byte(x, c);
      end
    end
    return x;
  endfunction

  function automatic ctx_t flush(ctx_t x);
    logic [7:0] second;
    second = x.h1;
    if (x.rc != CLS_NONE || x.sr != 2'd0) begin
      x = emit(x, x.h0, 1'b1);
    end else if (x.hc == 2'd1) begin
      x = apos_fallback(x);
      x = emit(x, ChApos, 1'b1);
    end else if (x.hc >= 2'd2) begin
      x = apos_fallback(x);
      x = emit(x, ChApos, 1'b1);
      x = emit(x, second, 1'b1);
    end
    return x;
  endfunction

  always_comb begin
    ctx_t x;
    x    = '0;
    x.h0 = h0_q;
    x.h1 = h1_q;
    x.hc = hc_q;
    x.rc = rc_q;
    x.sr = sr_q;
    x.pd = pd_q;
    x    = feed(x, in_char_i);
    if (last_of_text_i) begin
      x    = flush(x);
      x.h0 = 8'd0;
      x.h1 = 8'd0;
      x.hc = 2'd0;
      x.rc = CLS_NONE;
      x.sr = 2'd0;
      x.pd = 1'b0;
      if (x.b.cnt != '0) begin
        x.b.res[$clog2(MaxRes)'(x.b.cnt - CntW'(1))].text_end = 1'b1;
      end
    end
    h0_d     = x.h0;
    h1_d     = x.h1;
    hc_d     = x.hc;
    rc_d     = x.rc;
    sr_d     = x.sr;
    pd_d     = x.pd;
    bundle_o = x.b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q <= 2'd0;
      rc_q <= CLS_NONE;
      sr_q <= 2'd0;
      pd_q <= 1'b0;
    end else if (accept_i) begin
      hc_q <= hc_d;
      rc_q <= rc_d;
      sr_q <= sr_d;
      pd_q <= pd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      h0_q <= h0_d;
      h1_q <= h1_d;
    end
  end

endmodule

// ----- src/tps_queue.sv -----
module tps_queue import tps_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_en_i,
  input  bundle_t wr_data_i,
  output logic    full_o,
  input  logic    rd_en_i,
  output logic    rd_valid_o,
  output bundle_t rd_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntQW = $clog2(Depth + 1);

  bundle_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o     = cnt_q == CntQW'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) cnt_d = cnt_q + CntQW'(1);
    else if (!do_wr && do_rd) cnt_d = cnt_q - CntQW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- src/tps_back.sv -----
module tps_back import tps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  bundle_t    q_data_i,
  output logic       q_pop_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       chunk_end_o,
  output logic       text_end_o
);

  localparam int unsigned IdxW = $clog2(MaxRes);

  bundle_t         cur_q, cur_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            cvld_q, cvld_d;
  res_t            out_q, out_d;
  logic            ovld_q, ovld_d;
  logic            out_ready, take, last_slot, cur_free;

  assign out_ready = !ovld_q || pop;
  assign take      = cvld_q && out_ready;
  assign last_slot = CntW'(idx_q) == cur_q.cnt - CntW'(1);
  assign cur_free  = !cvld_q || (take && last_slot);
  assign q_pop_o   = q_valid_i && cur_free;

  always_comb begin
    cur_d  = cur_q;
    idx_d  = idx_q;
    cvld_d = cvld_q;
    if (q_pop_o) begin
      cur_d  = q_data_i;
      idx_d  = '0;
      cvld_d = 1'b1;
    end else if (take && last_slot) begin
      cvld_d = 1'b0;
    end else if (take) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_comb begin
    out_d  = out_q;
    ovld_d = ovld_q;
    if (out_ready) begin
      out_d  = cur_q.res[idx_q];
      ovld_d = cvld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q <= 1'b0;
      ovld_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      cvld_q <= cvld_d;
      ovld_q <= ovld_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign empty       = !ovld_q;
  assign out_char_o  = out_q.ch;
  assign chunk_end_o = out_q.chunk_end;
  assign text_end_o  = out_q.text_end;

endmodule

// ----- src/tps_checker.sv -----
module tps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char_o,
  input logic       chunk_end_o,
  input logic       text_end_o
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result shown during reset");

  a_text_end_closes_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && text_end_o) |-> chunk_end_o)
    else $error("text end on a result that does not close a chunk");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting result withdrawn");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(out_char_o) && $stable(chunk_end_o)
                          && $stable(text_end_o)))
    else $error("waiting result changed");

endmodule

bind text_pretokenizer_splitter tps_checker u_tps_checker (
  .clk_i,
  .rst_ni,
  .empty,
  .pop,
  .out_char_o,
  .chunk_end_o,
  .text_end_o
);
